// ----- rtl/sde_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sde_pkg
// shared opcodes, status codes and the front-to-back command type
// ----------------------------------------------------------------------------
package sde_pkg;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_READ   = 3'd1,
    OP_SNAP   = 3'd2,
    OP_GEN    = 3'd3,
    OP_APPLY  = 3'd4,
    OP_REC    = 3'd5,
    OP_ACK    = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_BASE  = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_NO_SEQ   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  localparam int RECORD_CAP = 64;

  // back end work classes
  typedef enum logic [2:0] {
    K_DONE  = 3'd0,   // single result, already resolved by the front
    K_READ  = 3'd1,   // read one byte
    K_SNAP  = 3'd2,   // copy store into a slot
    K_GEN   = 3'd3,   // count then emit deltas
    K_RESTO = 3'd4,   // copy a slot into the store
    K_WRITE = 3'd5    // write one byte (load or apply record)
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE, B_COUNT, B_EMIT, B_COPY, B_OUT
  } bstate_t;

endpackage

// ----- rtl/sde_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sde_front
// command decode, slot table and sequence bookkeeping
// ----------------------------------------------------------------------------
module sde_front #(
  parameter int STATE_BYTES   = 64,
  parameter int HISTORY_SLOTS = 8,
  parameter int AW = 6,
  parameter int SW = 3,
  parameter int ZW = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sde_pkg::op_t          op,
  input  logic [31:0]           off,
  input  logic [7:0]            val,
  input  logic                  lastb,
  input  logic [31:0]           seq,
  input  logic [6:0]            limit,
  output logic                  q_push,
  input  logic                  q_full,
  output sde_pkg::kind_t        q_kind,
  output sde_pkg::status_t      q_status,
  output logic [AW-1:0]         q_addr,
  output logic [7:0]            q_val,
  output logic                  q_size_set,
  output logic [ZW-1:0]         q_size,
  output logic                  q_grow,
  output logic                  q_inrange,
  output logic [SW-1:0]         q_slot,
  output logic [31:0]           q_seq,
  output logic [6:0]            q_limit
);
  import sde_pkg::*;

  logic [31:0]   slot_seq  [HISTORY_SLOTS];
  logic [ZW-1:0] slot_size [HISTORY_SLOTS];
  logic [HISTORY_SLOTS-1:0] slot_valid;
  logic [HISTORY_SLOTS-1:0] slot_acked;
  logic [SW-1:0] ring_head;
  logic [31:0]   seq_counter;
  logic          apply_allowed;
  // size as the front sees it, ahead of the back end
  logic [ZW-1:0] size_shadow;

  logic          hit;
  logic [SW-1:0] hit_idx;
  logic          inr;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = HISTORY_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_seq[i] == seq) begin
        hit = 1'b1;
        hit_idx = SW'(i);
      end
    end
  end

  assign inr      = off < 32'(STATE_BYTES);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_kind     = K_DONE;
    q_status   = ST_OK;
    q_addr     = off[AW-1:0];
    q_val      = val;
    q_size_set = 1'b0;
    q_size     = size_shadow;
    q_grow     = 1'b0;
    q_inrange  = inr;
    q_slot     = hit_idx;
    q_seq      = '0;
    q_limit    = (limit > 7'(RECORD_CAP)) ? 7'(RECORD_CAP) : limit;
    case (op)
      OP_LOAD: begin
        q_kind = inr ? K_WRITE : K_DONE;
        if (inr && lastb) begin
          q_size_set = 1'b1;
          q_size = ZW'(off[AW-1:0]) + ZW'(1);
        end
      end
      OP_READ: q_kind = K_READ;
      OP_SNAP: begin
        if (size_shadow == '0) q_status = ST_EMPTY;
        else begin
          q_kind = K_SNAP;
          q_slot = ring_head;
          q_seq  = seq_counter + 32'd1;
        end
      end
      OP_GEN: begin
        if (!hit) q_status = ST_NO_BASE;
        else q_kind = K_GEN;
      end
      OP_APPLY: begin
        if (seq != '0) begin
          if (!hit) q_status = ST_NO_BASE;
          else begin
            q_kind = K_RESTO;
            q_size_set = 1'b1;
            q_size = slot_size[hit_idx];
          end
        end
      end
      OP_REC: begin
        if (!apply_allowed) q_status = ST_NO_BASE;
        else if (inr) begin
          q_kind = K_WRITE;
          q_grow = 1'b1;
        end
      end
      OP_ACK: if (!hit) q_status = ST_NO_SEQ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_acked <= '0;
      ring_head <= '0;
      seq_counter <= '0;
      apply_allowed <= 1'b1;
      size_shadow <= '0;
      for (int i = 0; i < HISTORY_SLOTS; i++) begin
        slot_seq[i] <= '0;
        slot_size[i] <= '0;
      end
    end else if (q_push) begin
      if (q_size_set) size_shadow <= q_size;
      if (q_grow && ZW'(off[AW-1:0]) >= size_shadow)
        size_shadow <= ZW'(off[AW-1:0]) + ZW'(1);
      case (op)
        OP_SNAP: if (q_kind == K_SNAP) begin
          slot_seq[ring_head] <= q_seq;
          slot_size[ring_head] <= size_shadow;
          slot_valid[ring_head] <= 1'b1;
          slot_acked[ring_head] <= 1'b0;
          seq_counter <= q_seq;
          ring_head <= (ring_head == SW'(HISTORY_SLOTS - 1)) ? '0 : ring_head + SW'(1);
        end
        OP_APPLY: apply_allowed <= (seq == '0) || hit;
        OP_ACK: if (hit) slot_acked[hit_idx] <= 1'b1;
        default: ;
      endcase
    end
  end

  ap_head_range: assert property (@(posedge clk) disable iff (rst)
    ring_head <= SW'(HISTORY_SLOTS - 1)) else $error("ring head out of range");
  ap_snap_valid: assert property (@(posedge clk) disable iff (rst)
    q_push && q_kind == K_SNAP |=> slot_valid[$past(ring_head)])
    else $error("snapshot slot not marked");
  ap_seq_step: assert property (@(posedge clk) disable iff (rst)
    q_push && q_kind == K_SNAP |=> seq_counter == $past(seq_counter) + 32'd1)
    else $error("sequence did not advance");
endmodule

// ----- rtl/sde_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sde_queue
// small fifo between front and back
// ----------------------------------------------------------------------------
module sde_queue #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int PW = $clog2(DEPTH);
  logic [W-1:0] mem [DEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0] cnt;

  assign full  = cnt == (PW+1)'(DEPTH);
  assign empty = cnt == '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) wp <= wp + PW'(1);
      if (pop && !empty) rp <= rp + PW'(1);
      cnt <= cnt + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

  ap_no_over: assert property (@(posedge clk) disable iff (rst)
    cnt <= (PW+1)'(DEPTH)) else $error("queue count overflow");
  ap_cnt: assert property (@(posedge clk) disable iff (rst)
    push && !full && !(pop && !empty) |=> cnt == $past(cnt) + (PW+1)'(1))
    else $error("queue count slip");
  ap_empty: assert property (@(posedge clk) disable iff (rst)
    empty |=> !(cnt == (PW+1)'(DEPTH))) else $error("queue jumped to full");
endmodule

// ----- rtl/sde_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sde_back
// byte store, snapshot memory and the delta / copy sequencer
// ----------------------------------------------------------------------------
module sde_back #(
  parameter int STATE_BYTES   = 64,
  parameter int HISTORY_SLOTS = 8,
  parameter int AW = 6,
  parameter int SW = 3,
  parameter int ZW = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             c_valid,
  output logic             c_take,
  input  sde_pkg::kind_t   c_kind,
  input  sde_pkg::status_t c_status,
  input  logic [AW-1:0]    c_addr,
  input  logic [7:0]       c_val,
  input  logic             c_size_set,
  input  logic [ZW-1:0]    c_size,
  input  logic             c_grow,
  input  logic             c_inrange,
  input  logic [SW-1:0]    c_slot,
  input  logic [31:0]      c_seq,
  input  logic [6:0]       c_limit,
  output logic             empty,
  input  logic             pop,
  output logic [2:0]       status,
  output logic             has_record,
  output logic [5:0]       record_offset,
  output logic [7:0]       record_value,
  output logic [6:0]       store_size,
  output logic [31:0]      snapshot_sequence,
  output logic             last
);
  import sde_pkg::*;

  // one slot region per power-of-two stride of the store
  localparam int SNAP_DEPTH = HISTORY_SLOTS * (2 ** AW);

  logic [7:0] cur [STATE_BYTES];
  logic [STATE_BYTES-1:0] cur_written;
  logic [7:0] snap [SNAP_DEPTH];

  bstate_t state, state_next;
  logic [ZW-1:0] size;
  logic [AW:0]   idx;       // scan index, one extra bit for the end
  logic [AW:0]   pipe_idx;  // index of the byte pair in the read registers
  logic          pipe_v;
  logic [7:0]    cur_q, snap_q;
  logic [ZW-1:0] changes, emitted;
  kind_t         kind;
  logic [SW-1:0] slot;
  logic [AW-1:0] addr;
  logic [ZW-1:0] limit;
  logic          out_full;
  logic          out_free;
  logic [AW:0]   nbytes;
  logic          diff;
  logic          adv;

  // held result
  logic [2:0] o_status;
  logic o_hr, o_last;
  logic [5:0] o_off;
  logic [7:0] o_val;
  logic [31:0] o_seq;

  assign empty = !out_full;
  assign status = o_status;
  assign has_record = o_hr;
  assign record_offset = o_off;
  assign record_value = o_val;
  assign store_size = size;
  assign snapshot_sequence = o_seq;
  assign last = o_last;

  assign out_free = !out_full || pop;
  assign nbytes = (AW+1)'(size);
  assign diff = pipe_v && (cur_q != snap_q);

  always_comb begin
    state_next = state;
    c_take = 1'b0;
    case (state)
      B_IDLE: if (c_valid && out_free) begin
        c_take = 1'b1;
        case (c_kind)
          K_GEN:   state_next = B_COUNT;
          K_SNAP,
          K_RESTO: state_next = B_COPY;
          default: state_next = B_IDLE;
        endcase
      end
      B_COUNT: if (!pipe_v && idx >= nbytes && idx != '0 || (idx == '0 && nbytes == '0))
        state_next = B_OUT;
      B_EMIT: if (out_free && pipe_v && diff && emitted + ZW'(1) == changes)
        state_next = B_IDLE;
      B_COPY: if (idx == (AW+1)'(STATE_BYTES) && !pipe_v && out_free) state_next = B_IDLE;
      B_OUT: if (out_free)
        state_next = (changes == '0 || changes > limit) ? B_IDLE : B_EMIT;
      default: state_next = B_IDLE;
    endcase
  end

  // scan step enabled when the read pair can advance
  always_comb begin
    adv = 1'b0;
    if (state == B_COUNT) adv = 1'b1;
    if (state == B_EMIT) adv = !(pipe_v && diff) || out_free;
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && c_take) begin
      kind <= c_kind;
      slot <= c_slot;
      addr <= c_addr;
      limit <= ZW'(c_limit);
    end
    // read pair, held while a record waits for the result register
    if (state == B_COUNT || state == B_COPY || (state == B_EMIT && adv)) begin
      cur_q  <= cur_written[idx[AW-1:0]] ? cur[idx[AW-1:0]] : 8'd0;
      snap_q <= snap[{slot, idx[AW-1:0]}];
    end
    if (state == B_COPY && pipe_v && kind == K_SNAP)
      snap[{slot, pipe_idx[AW-1:0]}] <= cur_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      size <= '0;
      cur_written <= '0;
      out_full <= 1'b0;
      idx <= '0;
      pipe_v <= 1'b0;
      changes <= '0;
      emitted <= '0;
    end else begin
      state <= state_next;
      if (pop && out_full) out_full <= 1'b0;
      case (state)
        B_IDLE: if (c_take) begin
          idx <= '0;
          pipe_v <= 1'b0;
          changes <= '0;
          emitted <= '0;
          if (c_kind == K_WRITE) begin
            cur[c_addr] <= c_val;
            cur_written[c_addr] <= 1'b1;
          end
          if (c_size_set && c_kind != K_RESTO) size <= c_size;
          if (c_grow && ZW'(c_addr) >= size) size <= ZW'(c_addr) + ZW'(1);
          if (c_kind != K_GEN && c_kind != K_SNAP && c_kind != K_RESTO) begin
            out_full <= 1'b1;
            o_status <= c_status;
            o_hr <= 1'b0;
            o_off <= '0;
            o_val <= (c_kind == K_READ && c_inrange) ?
                     (cur_written[c_addr] ? cur[c_addr] : 8'd0) : 8'd0;
            o_seq <= '0;
            o_last <= 1'b1;
          end
          if (c_kind == K_SNAP) o_seq <= c_seq;
          if (c_kind == K_RESTO) begin
            o_seq <= '0;
            size <= c_size;
          end
        end
        B_COUNT: begin
          if (idx < nbytes) idx <= idx + (AW+1)'(1);
          pipe_v <= idx < nbytes;
          pipe_idx <= idx;
          if (diff) changes <= changes + ZW'(1);
        end
        B_OUT: if (out_free) begin
          idx <= '0;
          pipe_v <= 1'b0;
          if (changes == '0 || changes > limit) begin
            out_full <= 1'b1;
            o_status <= (changes == '0) ? ST_OK : ST_OVERFLOW;
            o_hr <= 1'b0;
            o_off <= '0;
            o_val <= '0;
            o_seq <= '0;
            o_last <= 1'b1;
          end
        end
        B_EMIT: if (adv) begin
          if (pipe_v && diff) begin
            out_full <= 1'b1;
            o_status <= ST_OK;
            o_hr <= 1'b1;
            o_off <= 6'(pipe_idx);
            o_val <= cur_q;
            o_seq <= '0;
            o_last <= emitted + ZW'(1) == changes;
            emitted <= emitted + ZW'(1);
          end
          if (idx < nbytes) idx <= idx + (AW+1)'(1);
          pipe_v <= idx < nbytes;
          pipe_idx <= idx;
        end
        B_COPY: begin
          // read at idx, write in the following cycle at pipe_idx
          if (idx < (AW+1)'(STATE_BYTES)) idx <= idx + (AW+1)'(1);
          pipe_v <= idx < (AW+1)'(STATE_BYTES);
          pipe_idx <= idx;
          if (pipe_v && kind == K_RESTO) begin
            cur[pipe_idx[AW-1:0]] <= snap_q;
            cur_written[pipe_idx[AW-1:0]] <= 1'b1;
          end
          if (idx == (AW+1)'(STATE_BYTES) && !pipe_v && out_free) begin
            out_full <= 1'b1;
            o_status <= ST_OK;
            o_hr <= 1'b0;
            o_off <= '0;
            o_val <= '0;
            o_last <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  ap_take_idle: assert property (@(posedge clk) disable iff (rst)
    c_take |-> state == B_IDLE) else $error("command taken while busy");
  ap_emit_bound: assert property (@(posedge clk) disable iff (rst)
    state == B_EMIT |-> emitted <= changes) else $error("emitted past change count");
  ap_size: assert property (@(posedge clk) disable iff (rst)
    size <= ZW'(STATE_BYTES)) else $error("size beyond store");
endmodule

// ----- rtl/snapshot_delta_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snapshot_delta_engine_core
// byte store with a snapshot ring and delta generation
//
// channel  | handshake      | beat contents
// input    | push / full    | operation, byte_index, byte_value, last_byte,
//          |                | sequence_number, record_limit
// result   | pop / empty    | status, has_record, record_offset, record_value,
//          |                | store_size, snapshot_sequence, last
//
// idle engine: a simple operation's beat is queued, then its result is registered
// snapshot and apply-begin move STATE_BYTES bytes through a registered read pair
// generate delta: count pass over size, then record pass if 0 < changes <= limit
// reset is synchronous; snapshot memory is not cleared (only valid slots read)
// a full result register stalls the back end; the queue holds four decoded beats
// ----------------------------------------------------------------------------
module snapshot_delta_engine_core #(
  parameter int STATE_BYTES   = 64,
  parameter int HISTORY_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [31:0] byte_index,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  input  logic [31:0] sequence_number,
  input  logic [6:0]  record_limit,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  status,
  output logic        has_record,
  output logic [5:0]  record_offset,
  output logic [7:0]  record_value,
  output logic [6:0]  store_size,
  output logic [31:0] snapshot_sequence,
  output logic        last
);
  import sde_pkg::*;

  localparam int AW = (STATE_BYTES > 1) ? $clog2(STATE_BYTES) : 1;
  localparam int SW = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
  localparam int ZW = 7;
  // kind, status, addr, val, size_set, size, grow, inrange, slot, seq, limit
  localparam int QW = 3 + 3 + AW + 8 + 1 + ZW + 1 + 1 + SW + 32 + 7;

  logic          f_push, q_full, q_empty, b_take, in_ready;
  kind_t         f_kind;
  status_t       f_status;
  logic [2:0]    b_kind, b_status;
  logic [AW-1:0] f_addr, b_addr;
  logic [7:0]    f_val, b_val;
  logic          f_sset, b_sset, f_grow, b_grow, f_inr, b_inr;
  logic [ZW-1:0] f_size, b_size;
  logic [SW-1:0] f_slot, b_slot;
  logic [31:0]   f_seq, b_seq;
  logic [6:0]    f_lim, b_lim;
  logic [QW-1:0] q_w, q_r;

  assign full = !in_ready;

  sde_front #(.STATE_BYTES(STATE_BYTES), .HISTORY_SLOTS(HISTORY_SLOTS),
              .AW(AW), .SW(SW), .ZW(ZW)) u_front (
    .clk, .rst, .in_valid(push), .in_ready,
    .op(op_t'(operation)), .off(byte_index), .val(byte_value),
    .lastb(last_byte), .seq(sequence_number), .limit(record_limit),
    .q_push(f_push), .q_full, .q_kind(f_kind), .q_status(f_status),
    .q_addr(f_addr), .q_val(f_val), .q_size_set(f_sset), .q_size(f_size),
    .q_grow(f_grow), .q_inrange(f_inr), .q_slot(f_slot), .q_seq(f_seq),
    .q_limit(f_lim)
  );

  assign q_w = {f_kind, f_status, f_addr, f_val, f_sset, f_size, f_grow, f_inr,
                f_slot, f_seq, f_lim};
  assign {b_kind, b_status, b_addr, b_val, b_sset, b_size, b_grow, b_inr,
          b_slot, b_seq, b_lim} = q_r;

  sde_queue #(.W(QW), .DEPTH(4)) u_queue (
    .clk, .rst, .push(f_push), .wdata(q_w), .full(q_full),
    .pop(b_take), .rdata(q_r), .empty(q_empty)
  );

  sde_back #(.STATE_BYTES(STATE_BYTES), .HISTORY_SLOTS(HISTORY_SLOTS),
             .AW(AW), .SW(SW), .ZW(ZW)) u_back (
    .clk, .rst, .c_valid(!q_empty), .c_take(b_take), .c_kind(kind_t'(b_kind)),
    .c_status(status_t'(b_status)), .c_addr(b_addr), .c_val(b_val),
    .c_size_set(b_sset), .c_size(b_size), .c_grow(b_grow), .c_inrange(b_inr),
    .c_slot(b_slot), .c_seq(b_seq), .c_limit(b_lim), .empty, .pop, .status,
    .has_record, .record_offset, .record_value, .store_size, .snapshot_sequence,
    .last
  );

  ap_full_stall: assert property (@(posedge clk) disable iff (rst)
    full |-> !f_push) else $error("front pushed into full queue");
  ap_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    b_take |-> !q_empty) else $error("back took from empty queue");
  ap_rec_last: assert property (@(posedge clk) disable iff (rst)
    !empty && !has_record |-> last) else $error("non-record result not last");
endmodule
